[src/affa_pkg.sv]
// Shared constants, types and state codes for the aligned first-fit range allocator.
// Depends on nothing; every other file imports it.
package affa_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int ADDR_BITS   = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int SIZE_W      = ADDR_BITS + 1;
    // Candidate starts can run past the address space by an alignment step and a boundary step.
    localparam int VAL_W       = ADDR_BITS + 3;

    localparam logic [ADDR_BITS-1:0] FIRST_FREE = ADDR_BITS'(256);
    localparam logic [ADDR_BITS-1:0] ADDR_MAX   = '1;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] lo;
        logic [ADDR_BITS-1:0] hi;
    } range_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        range_t           data;
    } tbl_wr_t;

    typedef struct packed {
        logic                 go;
        logic [VAL_W-1:0]     dividend;
        logic [ADDR_BITS-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_A_CHECK,
        S_A_WAIT,
        S_A_DIV1,
        S_A_DIV2,
        S_A_FIT,
        S_SH_RD,
        S_SH_WR,
        S_INS_HI,
        S_INS_LO,
        S_POST,
        S_MB_CHECK,
        S_MB_WAIT,
        S_DONE
    } state_t;

endpackage

[src/affa_rem.sv]
// Restoring remainder unit: one quotient bit per cycle.
// Depends on affa_pkg.
module affa_rem (
    input  logic                          clk,
    input  logic                          rst_n,
    input  affa_pkg::div_req_t            req,
    output logic                          done,
    output logic [affa_pkg::ADDR_BITS-1:0] rem
);
    import affa_pkg::*;

    localparam int CW = $clog2(VAL_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [VAL_W-1:0]     dvd_reg, dvd_next;
    logic [ADDR_BITS-1:0] dvs_reg, dvs_next;
    logic [ADDR_BITS-1:0] rem_reg, rem_next;
    logic [ADDR_BITS:0]   trial;

    always_comb
    begin
        trial     = {rem_reg, dvd_reg[VAL_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        if (req.go)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(VAL_W);
            dvd_next  = req.dividend;
            dvs_next  = req.divisor;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
                rem_next = ADDR_BITS'(trial - {1'b0, dvs_reg});
            else
                rem_next = trial[ADDR_BITS-1:0];
            dvd_next = {dvd_reg[VAL_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[src/affa_table.sv]
// Free range table: one write port, one registered read port.
// Depends on affa_pkg. Entry 0 reads as the initial range until first written.
module affa_table (
    input  logic                        clk,
    input  logic                        rst_n,
    input  affa_pkg::tbl_wr_t           wr,
    input  logic [affa_pkg::IDX_W-1:0]  raddr,
    output affa_pkg::range_t            rdata
);
    import affa_pkg::*;

    range_t mem [TABLE_DEPTH];
    range_t rd_reg;
    logic   e0_valid_reg;
    logic   dflt_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
        rd_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e0_valid_reg <= 1'b0;
            dflt_reg     <= 1'b0;
        end
        else
        begin
            if (wr.we && wr.addr == '0)
                e0_valid_reg <= 1'b1;
            dflt_reg <= (raddr == '0) && !e0_valid_reg;
        end
    end

    assign rdata = dflt_reg ? range_t'({FIRST_FREE, ADDR_MAX}) : rd_reg;

endmodule

[src/aligned_first_fit_range_allocator.sv]
// Top level of the aligned first-fit range allocator: control sequencer.
// Depends on affa_pkg, affa_table and affa_rem.
//
// One request at a time: a request is taken when start is high and busy low, and its
// answer appears on placed_address and status for the single cycle in which done is
// high; the receiver cannot stall it. Timing is set by the table's one read port and
// the bit-serial remainder unit. An allocate request visits ranges in order, taking
// the alignment and boundary remainders on a range when they are asked for, moving
// entries when a range is removed or split, and then the base move follows when
// pack mode is off. A move-base request scans ranges and moves entries on a split.
// After reset the block is ready at once.
module aligned_first_fit_range_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            kind,
    input  logic [affa_pkg::SIZE_W-1:0]     segment_size,
    input  logic [affa_pkg::ADDR_BITS-1:0]  align_to,
    input  logic [affa_pkg::ADDR_BITS-1:0]  boundary,
    input  logic [affa_pkg::ADDR_BITS-1:0]  new_base,
    input  logic                            pack_mode_we,
    input  logic                            pack_mode_wdata,
    output logic                            done,
    output logic [affa_pkg::ADDR_BITS-1:0]  placed_address,
    output logic [1:0]                      status
);
    import affa_pkg::*;

    state_t               state_reg, state_next;
    logic                 pack_reg;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     sfrom_reg, sfrom_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     pos_reg, pos_next;
    logic                 up_reg, up_next;
    logic                 mb_reg, mb_next;
    logic                 alloc_reg, alloc_next;
    status_t              status_reg, status_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [ADDR_BITS-1:0] al_reg, al_next;
    logic [ADDR_BITS-1:0] bnd_reg, bnd_next;
    logic [ADDR_BITS:0]   nb_reg, nb_next;
    logic [ADDR_BITS-1:0] s_reg, s_next;
    logic [ADDR_BITS-1:0] e_reg, e_next;
    logic [VAL_W-1:0]     eff_reg, eff_next;
    range_t               ins_reg, ins_next;
    range_t               lo_reg, lo_next;

    tbl_wr_t              tbl_wr;
    logic [IDX_W-1:0]     raddr;
    range_t               rdata;
    div_req_t             div_req;
    logic                 div_done;
    logic [ADDR_BITS-1:0] div_rem;

    logic [VAL_W-1:0]     eff1;
    logic [VAL_W-1:0]     last;
    logic [SIZE_W:0]      span;

    affa_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (tbl_wr),
        .raddr (raddr),
        .rdata (rdata)
    );

    affa_rem u_rem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .rem   (div_rem)
    );

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        sfrom_next  = sfrom_reg;
        idx_next    = idx_reg;
        k_next      = k_reg;
        pos_next    = pos_reg;
        up_next     = up_reg;
        mb_next     = mb_reg;
        alloc_next  = alloc_reg;
        status_next = status_reg;
        addr_next   = addr_reg;
        size_next   = size_reg;
        al_next     = al_reg;
        bnd_next    = bnd_reg;
        nb_next     = nb_reg;
        s_next      = s_reg;
        e_next      = e_reg;
        eff_next    = eff_reg;
        ins_next    = ins_reg;
        lo_next     = lo_reg;
        tbl_wr      = '0;
        raddr       = idx_reg[IDX_W-1:0];
        div_req     = '0;
        eff1        = (div_rem == '0) ? VAL_W'(s_reg)
                    : VAL_W'(s_reg) + VAL_W'(al_reg) - VAL_W'(div_rem);
        last        = eff_reg + VAL_W'(size_reg) - VAL_W'(1);
        span        = (SIZE_W+1)'(div_rem) + (SIZE_W+1)'(size_reg) - (SIZE_W+1)'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    size_next   = segment_size;
                    al_next     = align_to;
                    bnd_next    = boundary;
                    nb_next     = (ADDR_BITS+1)'(new_base);
                    addr_next   = '0;
                    alloc_next  = 1'b0;
                    idx_next    = '0;
                    if (kind)
                    begin
                        status_next = ST_OK;
                        state_next  = S_MB_CHECK;
                    end
                    else
                    begin
                        status_next = ST_NO_SPACE;
                        idx_next    = sfrom_reg;
                        state_next  = (segment_size == '0) ? S_DONE : S_A_CHECK;
                    end
                end
            end

            S_A_CHECK:
            begin
                if (idx_reg >= count_reg)
                    state_next = S_DONE;
                else
                    state_next = S_A_WAIT;
            end

            S_A_WAIT:
            begin
                s_next = rdata.lo;
                e_next = rdata.hi;
                if (al_reg != '0)
                begin
                    div_req.go       = 1'b1;
                    div_req.dividend = VAL_W'(rdata.lo);
                    div_req.divisor  = al_reg;
                    state_next       = S_A_DIV1;
                end
                else
                begin
                    eff_next = VAL_W'(rdata.lo);
                    if (bnd_reg != '0)
                    begin
                        div_req.go       = 1'b1;
                        div_req.dividend = VAL_W'(rdata.lo);
                        div_req.divisor  = bnd_reg;
                        state_next       = S_A_DIV2;
                    end
                    else
                        state_next = S_A_FIT;
                end
            end

            S_A_DIV1:
            begin
                if (div_done)
                begin
                    eff_next = eff1;
                    if (bnd_reg != '0)
                    begin
                        div_req.go       = 1'b1;
                        div_req.dividend = eff1;
                        div_req.divisor  = bnd_reg;
                        state_next       = S_A_DIV2;
                    end
                    else
                        state_next = S_A_FIT;
                end
            end

            S_A_DIV2:
            begin
                if (div_done)
                begin
                    // The segment straddles a boundary when its offset in the block plus
                    // its length runs past the block end.
                    if (span >= (SIZE_W+1)'(bnd_reg) && div_rem != '0)
                        eff_next = eff_reg - VAL_W'(div_rem) + VAL_W'(bnd_reg);
                    state_next = S_A_FIT;
                end
            end

            S_A_FIT:
            begin
                if (last > VAL_W'(e_reg))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_A_CHECK;
                end
                else if (eff_reg != VAL_W'(s_reg) && last != VAL_W'(e_reg)
                         && count_reg >= CNT_W'(TABLE_DEPTH))
                begin
                    status_next = ST_FULL;
                    state_next  = S_DONE;
                end
                else
                begin
                    status_next = ST_OK;
                    addr_next   = eff_reg[ADDR_BITS-1:0];
                    alloc_next  = 1'b1;
                    tbl_wr.addr = idx_reg[IDX_W-1:0];
                    if (eff_reg == VAL_W'(s_reg) && last == VAL_W'(e_reg))
                    begin
                        k_next     = idx_reg;
                        up_next    = 1'b0;
                        state_next = S_SH_RD;
                    end
                    else if (eff_reg == VAL_W'(s_reg))
                    begin
                        tbl_wr.we   = 1'b1;
                        tbl_wr.data = {ADDR_BITS'(last + VAL_W'(1)), e_reg};
                        state_next  = S_POST;
                    end
                    else if (last == VAL_W'(e_reg))
                    begin
                        tbl_wr.we   = 1'b1;
                        tbl_wr.data = {s_reg, ADDR_BITS'(eff_reg - VAL_W'(1))};
                        state_next  = S_POST;
                    end
                    else
                    begin
                        ins_next   = {ADDR_BITS'(last + VAL_W'(1)), e_reg};
                        lo_next    = {s_reg, ADDR_BITS'(eff_reg - VAL_W'(1))};
                        pos_next   = idx_reg + 1'b1;
                        k_next     = count_reg;
                        up_next    = 1'b1;
                        mb_next    = 1'b0;
                        state_next = S_SH_RD;
                    end
                end
            end

            S_SH_RD:
            begin
                if (up_reg)
                begin
                    raddr = IDX_W'(k_reg - 1'b1);
                    state_next = (k_reg > pos_reg) ? S_SH_WR : S_INS_HI;
                end
                else
                begin
                    raddr = IDX_W'(k_reg + 1'b1);
                    if (k_reg + 1'b1 < count_reg)
                        state_next = S_SH_WR;
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_POST;
                    end
                end
            end

            S_SH_WR:
            begin
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = k_reg[IDX_W-1:0];
                tbl_wr.data = rdata;
                k_next      = up_reg ? k_reg - 1'b1 : k_reg + 1'b1;
                state_next  = S_SH_RD;
            end

            S_INS_HI:
            begin
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = pos_reg[IDX_W-1:0];
                tbl_wr.data = ins_reg;
                state_next  = S_INS_LO;
            end

            S_INS_LO:
            begin
                tbl_wr.we   = 1'b1;
                tbl_wr.addr = IDX_W'(pos_reg - 1'b1);
                tbl_wr.data = lo_reg;
                count_next  = count_reg + 1'b1;
                if (mb_reg)
                begin
                    sfrom_next = pos_reg;
                    state_next = S_DONE;
                end
                else
                    state_next = S_POST;
            end

            S_POST:
            begin
                if (!pack_reg)
                begin
                    nb_next    = (ADDR_BITS+1)'(eff_reg + VAL_W'(size_reg));
                    idx_next   = '0;
                    state_next = S_MB_CHECK;
                end
                else
                    state_next = S_DONE;
            end

            S_MB_CHECK:
            begin
                if (idx_reg >= count_reg)
                begin
                    sfrom_next = idx_reg;
                    state_next = S_DONE;
                end
                else
                    state_next = S_MB_WAIT;
            end

            S_MB_WAIT:
            begin
                if (nb_reg > (ADDR_BITS+1)'(rdata.hi))
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_MB_CHECK;
                end
                else if ((ADDR_BITS+1)'(rdata.lo) >= nb_reg)
                begin
                    sfrom_next = idx_reg;
                    state_next = S_DONE;
                end
                else if (count_reg >= CNT_W'(TABLE_DEPTH))
                begin
                    if (!alloc_reg)
                        status_next = ST_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    ins_next   = {nb_reg[ADDR_BITS-1:0], rdata.hi};
                    lo_next    = {rdata.lo, ADDR_BITS'(nb_reg - 1'b1)};
                    pos_next   = idx_reg + 1'b1;
                    k_next     = count_reg;
                    up_next    = 1'b1;
                    mb_next    = 1'b1;
                    state_next = S_SH_RD;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pack_reg   <= 1'b0;
            count_reg  <= CNT_W'(1);
            sfrom_reg  <= '0;
            idx_reg    <= '0;
            k_reg      <= '0;
            pos_reg    <= '0;
            up_reg     <= 1'b0;
            mb_reg     <= 1'b0;
            alloc_reg  <= 1'b0;
            status_reg <= ST_OK;
            addr_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            sfrom_reg  <= sfrom_next;
            idx_reg    <= idx_next;
            k_reg      <= k_next;
            pos_reg    <= pos_next;
            up_reg     <= up_next;
            mb_reg     <= mb_next;
            alloc_reg  <= alloc_next;
            status_reg <= status_next;
            addr_reg   <= addr_next;
            if (pack_mode_we)
                pack_reg <= pack_mode_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        size_reg <= size_next;
        al_reg   <= al_next;
        bnd_reg  <= bnd_next;
        nb_reg   <= nb_next;
        s_reg    <= s_next;
        e_reg    <= e_next;
        eff_reg  <= eff_next;
        ins_reg  <= ins_next;
        lo_reg   <= lo_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign placed_address = addr_reg;
    assign status         = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("range count beyond table depth");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sfrom_reg <= count_reg)
        else $error("search index beyond range count");

    a_fail_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> placed_address == '0)
        else $error("failed request carries an address");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule
